[rtl/lfra_pkg.sv]
`default_nettype none
package lfra_pkg;

  localparam int unsigned MAX_ROOMS_DEF = 256;
  localparam int unsigned CUSTOMERS     = 256;
  localparam int unsigned CUST_W        = 8;
  localparam int unsigned ROOM_W        = 9;
  localparam int unsigned CNT_W         = 9;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned CHUNK_BITS    = 64;
  localparam int unsigned CHUNK_SEL_W   = 6;
  localparam int unsigned IN_DATA_W     = 8;
  localparam int unsigned OUT_DATA_W    = 32;

  localparam logic [ROOM_W-1:0] ROOMS_IN_USE_RST = 9'd256;

  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_DEPART = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_ROOM    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SEATED     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_SEATED = 2'd3;

  typedef struct packed {
    logic                capture;
    logic                scan_next;
    logic                seat;
    logic                unseat;
    logic                set_err;
    logic [STATUS_W-1:0] err_code;
    logic                load_out;
  } lfra_cmd_t;

  typedef struct packed {
    logic depart;
    logic seated;
    logic hit;
    logic last_chunk;
    logic out_stall;
  } lfra_stat_t;

endpackage
`default_nettype wire

[rtl/lfra_ctrl.sv]
`default_nettype none
module lfra_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  lfra_pkg::lfra_stat_t   stat,
  output lfra_pkg::lfra_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.err_code = lfra_pkg::ST_OK;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.depart) begin
          if (stat.seated) begin
            cmd.unseat = 1'b1;
          end else begin
            cmd.set_err  = 1'b1;
            cmd.err_code = lfra_pkg::ST_NOT_SEATED;
          end
          state_next = S_DONE;
        end else if (stat.seated) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = lfra_pkg::ST_SEATED;
          state_next   = S_DONE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        priority if (stat.hit) begin
          cmd.seat   = 1'b1;
          state_next = S_DONE;
        end else if (stat.last_chunk) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = lfra_pkg::ST_NO_ROOM;
          state_next   = S_DONE;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_DONE: begin
        // hold the result until the output register frees up
        if (!stat.out_stall) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

[rtl/lfra_datapath.sv]
`default_nettype none
module lfra_datapath #(
  parameter int unsigned MAX_ROOMS = lfra_pkg::MAX_ROOMS_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   in_op,
  input  wire  [lfra_pkg::CUST_W-1:0]           in_customer,
  input  wire                                   cfg_we,
  input  wire  [lfra_pkg::ROOM_W-1:0]           cfg_value,
  input  wire                                   out_ready,
  output logic                                  out_valid,
  output logic [lfra_pkg::ROOM_W-1:0]           out_room,
  output logic [lfra_pkg::CNT_W-1:0]            out_occupancy,
  output logic [lfra_pkg::CNT_W-1:0]            out_peak,
  output logic [lfra_pkg::STATUS_W-1:0]         out_status,
  input  lfra_pkg::lfra_cmd_t                   cmd,
  output lfra_pkg::lfra_stat_t                  stat
);

  localparam int unsigned ROOM_LIMIT = (1 << lfra_pkg::ROOM_W) - 1;
  localparam int unsigned ROOMS      = (MAX_ROOMS < ROOM_LIMIT) ? MAX_ROOMS : ROOM_LIMIT;
  localparam int unsigned NCHUNK_RAW = (ROOMS + lfra_pkg::CHUNK_BITS - 1) / lfra_pkg::CHUNK_BITS;
  localparam int unsigned CW         = (NCHUNK_RAW > 2) ? $clog2(NCHUNK_RAW) : 1;
  localparam int unsigned IW         = CW + lfra_pkg::CHUNK_SEL_W;
  localparam int unsigned NPAD       = 1 << IW;

  logic [lfra_pkg::ROOM_W-1:0]   rooms_in_use;
  logic [NPAD-1:0]               taken;
  logic [lfra_pkg::CUSTOMERS-1:0] seated;
  logic [lfra_pkg::ROOM_W-1:0]   cust_room [lfra_pkg::CUSTOMERS];
  logic [lfra_pkg::ROOM_W-1:0]   cust_room_rd;
  logic                          op_q;
  logic [lfra_pkg::CUST_W-1:0]   cust_q;
  logic [CW-1:0]                 chunk;
  logic [lfra_pkg::CNT_W-1:0]    occ;
  logic [lfra_pkg::CNT_W-1:0]    peak;
  logic [lfra_pkg::CNT_W-1:0]    occ_inc;
  logic [lfra_pkg::ROOM_W-1:0]   res_room;
  logic [lfra_pkg::STATUS_W-1:0] res_status;

  logic [lfra_pkg::CHUNK_BITS-1:0]  chunk_free;
  logic [lfra_pkg::CHUNK_BITS-1:0]  elig;
  logic [IW-1:0]                    gidx [lfra_pkg::CHUNK_BITS];
  logic                             hit;
  logic [lfra_pkg::CHUNK_SEL_W-1:0] hit_bit;
  logic [lfra_pkg::ROOM_W-1:0]      hit_room;
  logic [IW-1:0]                    free_idx;

  // lowest free room in the current 64-bit chunk, bounded by the configured room count
  always_comb begin
    chunk_free = ~taken[{chunk, {lfra_pkg::CHUNK_SEL_W{1'b0}}} +: lfra_pkg::CHUNK_BITS];
    hit        = 1'b0;
    hit_bit    = '0;
    for (int i = 0; i < lfra_pkg::CHUNK_BITS; i++) begin
      gidx[i] = {chunk, lfra_pkg::CHUNK_SEL_W'(i)};
      elig[i] = chunk_free[i] && (lfra_pkg::ROOM_W'(gidx[i]) < rooms_in_use);
    end
    for (int i = lfra_pkg::CHUNK_BITS - 1; i >= 0; i--) begin
      if (elig[i]) begin
        hit     = 1'b1;
        hit_bit = lfra_pkg::CHUNK_SEL_W'(i);
      end
    end
    hit_room = lfra_pkg::ROOM_W'({chunk, hit_bit}) + 1'b1;
    free_idx = IW'(cust_room_rd - 1'b1);
    occ_inc  = occ + 1'b1;
  end

  assign stat.depart     = (op_q == lfra_pkg::OP_DEPART);
  assign stat.seated     = seated[cust_q];
  assign stat.hit        = hit;
  assign stat.last_chunk = (chunk == CW'(NCHUNK_RAW - 1));
  assign stat.out_stall  = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rooms_in_use <= lfra_pkg::ROOMS_IN_USE_RST;
    end else if (cfg_we) begin
      rooms_in_use <= cfg_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cust_room_rd <= cust_room[in_customer];
    end
    if (cmd.seat) begin
      cust_room[cust_q] <= hit_room;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= in_op;
      cust_q <= in_customer;
    end
    if (cmd.seat) begin
      res_room   <= hit_room;
      res_status <= lfra_pkg::ST_OK;
    end else if (cmd.unseat) begin
      res_room   <= cust_room_rd;
      res_status <= lfra_pkg::ST_OK;
    end else if (cmd.set_err) begin
      res_room   <= '0;
      res_status <= cmd.err_code;
    end
    if (cmd.load_out) begin
      out_room      <= res_room;
      out_occupancy <= occ;
      out_peak      <= peak;
      out_status    <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      // pad rooms beyond the array are marked taken and never freed
      for (int i = 0; i < NPAD; i++) begin
        taken[i] <= (i >= ROOMS);
      end
      seated    <= '0;
      occ       <= '0;
      peak      <= '0;
      chunk     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.capture) begin
        chunk <= '0;
      end else if (cmd.scan_next) begin
        chunk <= chunk + 1'b1;
      end
      if (cmd.seat) begin
        taken[{chunk, hit_bit}] <= 1'b1;
        seated[cust_q]          <= 1'b1;
        occ                     <= occ_inc;
        if (occ_inc > peak) begin
          peak <= occ_inc;
        end
      end else if (cmd.unseat) begin
        taken[free_idx] <= 1'b0;
        seated[cust_q]  <= 1'b0;
        occ             <= occ - 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/lowest_free_room_allocator_unit.sv]
`default_nettype none
// Lowest-free room allocator. Each input beat is an arrive (tuser 0) or depart (tuser 1)
// event for one customer; each event returns exactly one result beat with the room
// assigned or freed, the occupancy after the event, the peak occupancy since reset and
// a status code (ok, no free room, already seated, not seated). Rooms 1 up to the
// configured count (capped by MAX_ROOMS) may be assigned; write the count only while
// the block is idle. An arrival scans the free map one 64-bit chunk per cycle, from chunk 0
// until it finds a free room; the number of 64-room chunks scanned is 1 up to 4 at the
// default 256 rooms, all chunks when none is free. A departure does not scan the free map.
// A new event is taken while the previous result still waits on the output register.
module lowest_free_room_allocator_unit #(
  parameter int unsigned MAX_ROOMS = lfra_pkg::MAX_ROOMS_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [lfra_pkg::ROOM_W-1:0]        cfg_data,     // rooms_in_use
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire  [lfra_pkg::IN_DATA_W-1:0]     s_axis_tdata, // [7:0] customer
  input  wire                                s_axis_tuser, // [0] operation
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // [8:0] room, [17:9] occupancy, [26:18] peak_occupancy, [28:27] status, rest zero
  output logic [lfra_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  lfra_pkg::lfra_cmd_t  cmd;
  lfra_pkg::lfra_stat_t stat;

  logic [lfra_pkg::ROOM_W-1:0]   out_room;
  logic [lfra_pkg::CNT_W-1:0]    out_occupancy;
  logic [lfra_pkg::CNT_W-1:0]    out_peak;
  logic [lfra_pkg::STATUS_W-1:0] out_status;

  assign cfg_ready = 1'b1;

  lfra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lfra_datapath #(
    .MAX_ROOMS (MAX_ROOMS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .in_op         (s_axis_tuser),
    .in_customer   (s_axis_tdata[lfra_pkg::CUST_W-1:0]),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_value     (cfg_data),
    .out_ready     (m_axis_tready),
    .out_valid     (m_axis_tvalid),
    .out_room      (out_room),
    .out_occupancy (out_occupancy),
    .out_peak      (out_peak),
    .out_status    (out_status),
    .cmd           (cmd),
    .stat          (stat)
  );

  assign m_axis_tdata = {3'b000, out_status, out_peak, out_occupancy, out_room};

endmodule
`default_nettype wire
